// ===== design/signed_int_to_decimal_ascii_core_assert.svh =====
// Assertion macros for the signed integer to decimal ASCII core.
// Included by the top level only; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// same-cycle implication
`define SITDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII core.
// Used by sitda_ctrl, sitda_dp and the top level.
package sitda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 7;
  localparam int NDIGITS   = 10;
  localparam int BCD_W     = 4 * NDIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int NSTEPS    = VALUE_W / BITS_PER_STEP;
  localparam int CNT_W     = $clog2(NSTEPS);
  localparam int DIG_CNT_W = $clog2(NDIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic align;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic neg;
    logic dig_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/sitda_ctrl.sv =====
// Controller FSM: sequences load, BCD conversion, alignment and character output.
// Depends on sitda_pkg.
module sitda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sitda_pkg::sts_t  sts,
  output sitda_pkg::cmd_t  cmd
);
  import sitda_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        state_next = sts.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (sts.out_free) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts.out_free && sts.dig_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.step = 1'b1;
      ST_ALIGN: cmd.align = 1'b1;
      ST_SIGN:  cmd.emit_sign = sts.out_free;
      ST_DIGIT: cmd.emit_digit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== design/sitda_dp.sv =====
// Datapath: magnitude register, double-dabble BCD converter, leading-zero
// alignment and output character register. Depends on sitda_pkg.
module sitda_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sitda_pkg::cmd_t                  cmd,
  input  logic [sitda_pkg::VALUE_W-1:0]    value,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [sitda_pkg::CHAR_W-1:0]     character,
  output logic                             last,
  output sitda_pkg::sts_t                  sts
);
  import sitda_pkg::*;

  logic [VALUE_W-1:0]   mag;
  logic                 neg;
  logic [BCD_W-1:0]     bcd;
  logic [CNT_W-1:0]     cnt;
  logic [DIG_CNT_W-1:0] rem;

  logic [VALUE_W-1:0]   mag_next;
  logic [BCD_W-1:0]     bcd_step;
  logic [DIG_CNT_W-1:0] lead;
  logic                 found;
  logic                 out_free;

  function automatic logic [BCD_W-1:0] dd_bit(input logic [BCD_W-1:0] b,
                                              input logic in_bit);
    logic [BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < NDIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) a[4*i +: 4] = b[4*i +: 4] + 4'd3;
    end
    return {a[BCD_W-2:0], in_bit};
  endfunction

  always_comb begin
    bcd_step = bcd;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      bcd_step = dd_bit(bcd_step, mag[VALUE_W-1-k]);
    end
    mag_next = mag << BITS_PER_STEP;
  end

  // leading zero digits, capped so one digit always remains
  always_comb begin
    lead  = '0;
    found = 1'b0;
    for (int i = NDIGITS - 1; i > 0; i--) begin
      if (!found && bcd[4*i +: 4] == 4'd0) lead = lead + 1'b1;
      else found = 1'b1;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? (~value + 1'b1) : value;
      bcd <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      mag <= mag_next;
      bcd <= bcd_step;
      cnt <= cnt + 1'b1;
    end else if (cmd.align) begin
      bcd <= bcd << {lead, 2'b00};
      rem <= DIG_CNT_W'(NDIGITS) - lead;
    end else if (cmd.emit_digit) begin
      bcd <= bcd << 4;
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= ASCII_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= ASCII_ZERO + {3'b000, bcd[BCD_W-1 -: 4]};
      last      <= (rem == DIG_CNT_W'(1));
    end
  end

  assign sts.conv_last = (cnt == CNT_W'(NSTEPS - 1));
  assign sts.neg       = neg;
  assign sts.dig_last  = (rem == DIG_CNT_W'(1));
  assign sts.out_free  = out_free;

endmodule

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// Each value passes a 16-step double-dabble conversion (2 bits/step), then an
// alignment step, and is emitted as 1 to 11 characters (sign and up to 10 digits),
// one character/cycle while the output is not stalled.
// Input is taken only while the controller is idle; output stalls hold the sequence.
// Reset (rst, synchronous) returns the controller to idle and empties the output.
`include "signed_int_to_decimal_ascii_core_assert.svh"
module signed_int_to_decimal_ascii_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sitda_pkg::VALUE_W-1:0]  value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]   character,
  output logic                           last
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitda_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .character (character),
    .last      (last),
    .sts       (sts)
  );

  `SITDA_ASSERT_NEXT(a_no_back_to_back, clk, rst, in_valid && !in_stall, in_stall, "input accepted while busy")
  `SITDA_ASSERT_NEXT(a_chars_contiguous, clk, rst, out_valid && !out_stall && !last, out_valid, "gap inside number text")
  `SITDA_ASSERT_NOW(a_minus_not_last, clk, rst, out_valid && character == ASCII_MINUS, !last, "minus sign flagged last")
  `SITDA_ASSERT_NOW(a_sign_only_neg, clk, rst, cmd.emit_sign, sts.neg, "sign emitted for non-negative value")

endmodule
